[src/mgha_pkg.sv]
// Shared types and fixed widths for the marginal gain heap allocator.
package mgha_pkg;

    localparam int EXTRA_W = 16;
    localparam int FRAC_W  = 32;
    localparam int RATIO_W = 33;

    typedef struct packed {
        logic busy;
        logic done;
    } mgha_unit_status_t;

endpackage

[src/marginal_gain_heap_allocator_unit.sv]
// Top level: heap memory and sequencer of the greedy marginal gain allocator.
// Groups arrive one request at a time and are pushed into a binary max-heap held in
// an on-chip memory; each level that a push climbs costs a parent read, a compare start
// and an exact gain compare on the single shared multiplier. On a request with last
// set, each of the extra_students allocations pops the root, sifts down (up to two
// compares per level) and pushes it back; the mean is then formed with the bit-serial
// divider, one division per group held plus one final division of the sum by the group
// count. The heap needs no clearing pass: entries at or above the size count are never
// read. The result sits in an output register; s_ready is high only while the sequencer
// is idle.
module marginal_gain_heap_allocator_unit #(
    parameter int MAX_CLASSES = 1024,
    parameter int COUNT_WIDTH = 17
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mgha_pkg::EXTRA_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [COUNT_WIDTH-1:0]            s_pass_count,
    input  logic [COUNT_WIDTH-1:0]            s_total_count,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mgha_pkg::RATIO_W-1:0]      m_average_ratio,
    output logic                              m_overflow
);

    localparam int EW    = (COUNT_WIDTH > mgha_pkg::EXTRA_W ? COUNT_WIDTH
                                                            : mgha_pkg::EXTRA_W) + 1;
    localparam int IDX_W = $clog2(MAX_CLASSES);
    localparam int SZ_W  = $clog2(MAX_CLASSES + 1);
    localparam int CH_W  = IDX_W + 2;
    localparam int KW    = SZ_W > mgha_pkg::EXTRA_W ? SZ_W : mgha_pkg::EXTRA_W;
    localparam int SUM_W = mgha_pkg::RATIO_W + IDX_W;
    localparam int NUM_W = (EW + mgha_pkg::FRAC_W) > SUM_W ? (EW + mgha_pkg::FRAC_W) : SUM_W;
    localparam int DEN_W = EW > SZ_W ? EW : SZ_W;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_UP      = 5'd1;
    localparam logic [4:0] ST_UP_RD   = 5'd2;
    localparam logic [4:0] ST_UP_CMP  = 5'd3;
    localparam logic [4:0] ST_ACHK    = 5'd4;
    localparam logic [4:0] ST_POP0    = 5'd5;
    localparam logic [4:0] ST_POP1    = 5'd6;
    localparam logic [4:0] ST_DN      = 5'd7;
    localparam logic [4:0] ST_DN_L    = 5'd8;
    localparam logic [4:0] ST_DN_LC   = 5'd9;
    localparam logic [4:0] ST_DN_R    = 5'd10;
    localparam logic [4:0] ST_DN_RC   = 5'd11;
    localparam logic [4:0] ST_DN_DEC  = 5'd12;
    localparam logic [4:0] ST_AVG     = 5'd13;
    localparam logic [4:0] ST_AVG_RD  = 5'd14;
    localparam logic [4:0] ST_AVG_W   = 5'd15;
    localparam logic [4:0] ST_AVG_DIV = 5'd16;
    localparam logic [4:0] ST_AVG_DW  = 5'd17;
    localparam logic [4:0] ST_FIN     = 5'd18;

    logic [4:0]                    state_reg, state_next;
    logic [SZ_W-1:0]               size_reg, size_next;
    logic                          dropped_reg, dropped_next;
    logic [mgha_pkg::EXTRA_W-1:0]  extra_reg;
    logic                          last_reg, last_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [IDX_W-1:0]              best_idx_reg, best_idx_next;
    logic                          best_cur_reg, best_cur_next;
    logic [EW-1:0]                 cur_p_reg, cur_p_next, cur_t_reg, cur_t_next;
    logic [EW-1:0]                 best_p_reg, best_p_next, best_t_reg, best_t_next;
    logic [EW-1:0]                 cand_p_reg, cand_p_next, cand_t_reg, cand_t_next;
    logic [EW-1:0]                 rp_reg, rp_next, rt_reg, rt_next;
    logic [KW-1:0]                 k_reg, k_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [mgha_pkg::RATIO_W-1:0]  avg_reg, avg_next;
    logic [mgha_pkg::RATIO_W-1:0]  ratio_reg, ratio_next;
    logic                          ovf_reg, ovf_next;
    logic                          m_valid_reg, m_valid_next;

    logic [2*EW-1:0]               heap_mem [MAX_CLASSES];
    logic [2*EW-1:0]               mem_rdata_reg, mem_wdata;
    logic [IDX_W-1:0]              mem_raddr, mem_waddr;
    logic                          mem_we;
    logic [EW-1:0]                 rd_p, rd_t;

    logic                          cmp_start, cmp_gt;
    logic [EW-1:0]                 cmp_ap, cmp_at, cmp_bp, cmp_bt;
    mgha_pkg::mgha_unit_status_t   cmp_status, div_status;
    logic                          div_start;
    logic [NUM_W-1:0]              div_num, div_quot;
    logic [DEN_W-1:0]              div_den;

    logic [COUNT_WIDTH-1:0]        in_t, in_p;
    logic [CH_W-1:0]               l_idx, r_idx, size_ch;
    logic [IDX_W-1:0]              par_idx;
    logic [4:0]                    after_push;

    assign rd_p    = mem_rdata_reg[2*EW-1:EW];
    assign rd_t    = mem_rdata_reg[EW-1:0];
    assign in_t    = (s_total_count == '0) ? COUNT_WIDTH'(1) : s_total_count;
    assign in_p    = (s_pass_count > in_t) ? in_t : s_pass_count;
    assign l_idx   = {1'b0, idx_reg, 1'b1};
    assign r_idx   = l_idx + CH_W'(1);
    assign size_ch = CH_W'(size_reg);
    assign par_idx = (idx_reg - IDX_W'(1)) >> 1;
    assign after_push = last_reg ? ST_ACHK : ST_IDLE;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= heap_mem[mem_raddr];
    end

    mgha_cmp #(.EW(EW)) u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmp_start),
        .a_pass  (cmp_ap),
        .a_total (cmp_at),
        .b_pass  (cmp_bp),
        .b_total (cmp_bt),
        .status  (cmp_status),
        .gt      (cmp_gt)
    );

    mgha_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .status  (div_status),
        .quot    (div_quot)
    );

    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        dropped_next  = dropped_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_cur_next = best_cur_reg;
        cur_p_next    = cur_p_reg;
        cur_t_next    = cur_t_reg;
        best_p_next   = best_p_reg;
        best_t_next   = best_t_reg;
        cand_p_next   = cand_p_reg;
        cand_t_next   = cand_t_reg;
        rp_next       = rp_reg;
        rt_next       = rt_reg;
        k_next        = k_reg;
        sum_next      = sum_reg;
        avg_next      = avg_reg;
        ratio_next    = ratio_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = {cur_p_reg, cur_t_reg};
        mem_raddr     = '0;
        cmp_start     = 1'b0;
        cmp_ap        = rd_p;
        cmp_at        = rd_t;
        cmp_bp        = cur_p_reg;
        cmp_bt        = cur_t_reg;
        div_start     = 1'b0;
        div_num       = NUM_W'({rd_p, {mgha_pkg::FRAC_W{1'b0}}});
        div_den       = DEN_W'(rd_t);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next  = s_last;
                    cur_p_next = EW'(in_p);
                    cur_t_next = EW'(in_t);
                    if (size_reg < SZ_W'(MAX_CLASSES)) begin
                        idx_next   = size_reg[IDX_W-1:0];
                        size_next  = size_reg + SZ_W'(1);
                        state_next = ST_UP;
                    end else begin
                        dropped_next = 1'b1;
                        state_next   = s_last ? ST_ACHK : ST_IDLE;
                    end
                end
            end
            ST_UP: begin
                mem_raddr = par_idx;
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = after_push;
                end else begin
                    state_next = ST_UP_RD;
                end
            end
            ST_UP_RD: begin
                cmp_start   = 1'b1;
                cmp_ap      = cur_p_reg;
                cmp_at      = cur_t_reg;
                cmp_bp      = rd_p;
                cmp_bt      = rd_t;
                cand_p_next = rd_p;
                cand_t_next = rd_t;
                state_next  = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                if (cmp_status.done) begin
                    mem_we = 1'b1;
                    if (cmp_gt) begin
                        // The parent moves down into the hole and the climb goes on.
                        mem_wdata  = {cand_p_reg, cand_t_reg};
                        idx_next   = par_idx;
                        state_next = ST_UP;
                    end else begin
                        state_next = after_push;
                    end
                end
            end
            ST_ACHK: begin
                mem_raddr = '0;
                if ((k_reg < KW'(extra_reg)) && (size_reg != '0)) begin
                    state_next = ST_POP0;
                end else begin
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = ST_AVG;
                end
            end
            ST_POP0: begin
                rp_next    = rd_p;
                rt_next    = rd_t;
                mem_raddr  = IDX_W'(size_reg - SZ_W'(1));
                state_next = ST_POP1;
            end
            ST_POP1: begin
                cur_p_next = rd_p;
                cur_t_next = rd_t;
                size_next  = size_reg - SZ_W'(1);
                idx_next   = '0;
                k_next     = k_reg + KW'(1);
                state_next = ST_DN;
            end
            ST_DN: begin
                mem_raddr = l_idx[IDX_W-1:0];
                if (l_idx < size_ch) begin
                    state_next = ST_DN_L;
                end else begin
                    // No children: the moved entry settles here and the popped group
                    // goes back in with one more member.
                    mem_we     = 1'b1;
                    cur_p_next = rp_reg + EW'(1);
                    cur_t_next = rt_reg + EW'(1);
                    idx_next   = size_reg[IDX_W-1:0];
                    size_next  = size_reg + SZ_W'(1);
                    state_next = ST_UP;
                end
            end
            ST_DN_L: begin
                cmp_start   = 1'b1;
                cand_p_next = rd_p;
                cand_t_next = rd_t;
                state_next  = ST_DN_LC;
            end
            ST_DN_LC: begin
                mem_raddr = r_idx[IDX_W-1:0];
                if (cmp_status.done) begin
                    best_cur_next = !cmp_gt;
                    if (cmp_gt) begin
                        best_p_next   = cand_p_reg;
                        best_t_next   = cand_t_reg;
                        best_idx_next = l_idx[IDX_W-1:0];
                    end
                    state_next = (r_idx < size_ch) ? ST_DN_R : ST_DN_DEC;
                end
            end
            ST_DN_R: begin
                cmp_start   = 1'b1;
                cmp_bp      = best_cur_reg ? cur_p_reg : best_p_reg;
                cmp_bt      = best_cur_reg ? cur_t_reg : best_t_reg;
                cand_p_next = rd_p;
                cand_t_next = rd_t;
                state_next  = ST_DN_RC;
            end
            ST_DN_RC: begin
                if (cmp_status.done) begin
                    if (cmp_gt) begin
                        best_cur_next = 1'b0;
                        best_p_next   = cand_p_reg;
                        best_t_next   = cand_t_reg;
                        best_idx_next = r_idx[IDX_W-1:0];
                    end
                    state_next = ST_DN_DEC;
                end
            end
            ST_DN_DEC: begin
                mem_we = 1'b1;
                if (best_cur_reg) begin
                    cur_p_next = rp_reg + EW'(1);
                    cur_t_next = rt_reg + EW'(1);
                    idx_next   = size_reg[IDX_W-1:0];
                    size_next  = size_reg + SZ_W'(1);
                    state_next = ST_UP;
                end else begin
                    mem_wdata  = {best_p_reg, best_t_reg};
                    idx_next   = best_idx_reg;
                    state_next = ST_DN;
                end
            end
            ST_AVG: begin
                mem_raddr = k_reg[IDX_W-1:0];
                state_next = (k_reg < KW'(size_reg)) ? ST_AVG_RD : ST_AVG_DIV;
            end
            ST_AVG_RD: begin
                div_start  = 1'b1;
                state_next = ST_AVG_W;
            end
            ST_AVG_W: begin
                if (div_status.done) begin
                    sum_next   = sum_reg + SUM_W'(div_quot);
                    k_next     = k_reg + KW'(1);
                    state_next = ST_AVG;
                end
            end
            ST_AVG_DIV: begin
                div_num = NUM_W'(sum_reg);
                div_den = DEN_W'(size_reg);
                if (size_reg == '0) begin
                    avg_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_AVG_DW;
                end
            end
            ST_AVG_DW: begin
                if (div_status.done) begin
                    avg_next   = div_quot[mgha_pkg::RATIO_W-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    ratio_next   = avg_reg;
                    ovf_next     = dropped_reg;
                    size_next    = '0;
                    dropped_next = 1'b0;
                    k_next       = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_cur_reg <= best_cur_next;
        cur_p_reg    <= cur_p_next;
        cur_t_reg    <= cur_t_next;
        best_p_reg   <= best_p_next;
        best_t_reg   <= best_t_next;
        cand_p_reg   <= cand_p_next;
        cand_t_reg   <= cand_t_next;
        rp_reg       <= rp_next;
        rt_reg       <= rt_next;
        sum_reg      <= sum_next;
        avg_reg      <= avg_next;
        ratio_reg    <= ratio_next;
        ovf_reg      <= ovf_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= '0;
            dropped_reg <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
            extra_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            dropped_reg <= dropped_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                extra_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_average_ratio = ratio_reg;
    assign m_overflow      = ovf_reg;

endmodule

[src/mgha_cmp.sv]
// Exact gain compare of two groups by cross-multiplication through one multiplier.
module mgha_cmp #(
    parameter int EW = 18
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [EW-1:0]              a_pass,
    input  logic [EW-1:0]              a_total,
    input  logic [EW-1:0]              b_pass,
    input  logic [EW-1:0]              b_total,
    output mgha_pkg::mgha_unit_status_t status,
    output logic                       gt
);

    localparam int MW = EW + 1;

    logic [EW-1:0]   da_reg, db_reg, ta_reg, tb_reg;
    logic [2*EW-1:0] qa_reg, qb_reg;
    logic [3*EW-1:0] lhs_reg, rhs_reg;
    logic [2*MW-1:0] prod_reg;
    logic [2:0]      step_reg;
    logic            busy_reg, done_reg, gt_reg;
    logic [MW-1:0]   op_x, op_y;
    logic [3*EW-1:0] prod_lo, prod_hi;

    assign prod_lo = (3*EW)'(prod_reg[2*EW-1:0]);
    assign prod_hi = {prod_reg[2*EW-1:0], {EW{1'b0}}};

    // Step order: qa, qb, db*qa low/high half, da*qb low/high half.
    always_comb begin
        case (step_reg)
            3'd0:    begin op_x = MW'(ta_reg); op_y = MW'(ta_reg) + MW'(1); end
            3'd1:    begin op_x = MW'(tb_reg); op_y = MW'(tb_reg) + MW'(1); end
            3'd2:    begin op_x = MW'(db_reg); op_y = MW'(qa_reg[EW-1:0]); end
            3'd3:    begin op_x = MW'(db_reg); op_y = MW'(qa_reg[2*EW-1:EW]); end
            3'd4:    begin op_x = MW'(da_reg); op_y = MW'(qb_reg[EW-1:0]); end
            3'd5:    begin op_x = MW'(da_reg); op_y = MW'(qb_reg[2*EW-1:EW]); end
            default: begin op_x = '0; op_y = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_x * op_y;
        if (start) begin
            da_reg <= a_total - a_pass;
            db_reg <= b_total - b_pass;
            ta_reg <= a_total;
            tb_reg <= b_total;
        end
        case (step_reg)
            3'd1:    qa_reg <= prod_reg[2*EW-1:0];
            3'd2:    qb_reg <= prod_reg[2*EW-1:0];
            3'd3:    rhs_reg <= prod_lo;
            3'd4:    rhs_reg <= rhs_reg + prod_hi;
            3'd5:    lhs_reg <= prod_lo;
            3'd6:    lhs_reg <= lhs_reg + prod_hi;
            default: ;
        endcase
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            gt_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    gt_reg   <= lhs_reg > rhs_reg;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign gt          = gt_reg;

endmodule

[src/mgha_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module mgha_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 18
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    output mgha_pkg::mgha_unit_status_t status,
    output logic [NUM_W-1:0]           quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = q_reg;

endmodule

[src/mgha_checker.sv]
// Port-level checks for the allocator, bound to its top level.
module mgha_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_last,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [mgha_pkg::RATIO_W-1:0] m_average_ratio,
    input logic                         m_overflow
);

    // A waiting result holds still until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average_ratio) && $stable(m_overflow))
        else $error("result changed while stalled");

    // The mean of ratios never exceeds one in Q1.32.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_average_ratio[32] || (m_average_ratio[31:0] == '0)))
        else $error("average ratio above one");

    // A request that closes a set always starts allocation work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("ready after closing request");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind marginal_gain_heap_allocator_unit mgha_checker u_mgha_checker (.*);
